FILE: design/led_brightness_fade_sequencer_core_macros.svh
// assertion macros for the led brightness fade sequencer
`ifndef LED_BRIGHTNESS_FADE_SEQUENCER_CORE_MACROS_SVH
`define LED_BRIGHTNESS_FADE_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LBFS_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbfs check failed");
`define LBFS_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbfs check failed");
`else
`define LBFS_CHECK(label, ante, cons)
`define LBFS_CHECK_NEXT(label, ante, cons)
`endif
`endif

FILE: design/lbfs_pkg.sv
// shared types, codes and helpers of the led brightness fade sequencer
package lbfs_pkg;

  localparam int LEVEL_W = 8;
  localparam int MODE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int PCMD_W  = 2;
  localparam int CFG_A_W = 2;
  localparam int PROD_W  = 2 * LEVEL_W;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(PROD_W - 1);
  localparam logic [MODE_W-1:0]  NO_MODE    = 8'hFF;
  localparam logic [LEVEL_W-1:0] DEFAULT_ON = 8'd128;

  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FADE_IN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FADE_OUT = 2'd2;

  localparam logic [PCMD_W-1:0] PCMD_NONE    = 2'd0;
  localparam logic [PCMD_W-1:0] PCMD_ENABLE  = 2'd1;
  localparam logic [PCMD_W-1:0] PCMD_DISABLE = 2'd2;

  localparam logic [CFG_A_W-1:0] CFG_POWER_STEP = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_OUT_STEPS  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_IN_STEPS   = 2'd2;

  localparam logic [LEVEL_W-1:0] RST_POWER_STEP = 8'd8;
  localparam logic [LEVEL_W-1:0] RST_OUT_STEPS  = 8'd16;
  localparam logic [LEVEL_W-1:0] RST_IN_STEPS   = 8'd16;

  typedef struct packed {
    logic [KIND_W-1:0]  mode;
    logic [MODE_W-1:0]  effect_mode_in;
    logic [LEVEL_W-1:0] level_in;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_out;
    logic               apply_mode;
    logic [MODE_W-1:0]  effect_mode_out;
    logic [PCMD_W-1:0]  power_cmd;
    logic               busy_res;
  } out_word_t;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  dividend;
    logic [LEVEL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quot;
  } div_rsp_t;

  // move from toward dest by at most step
  function automatic logic [LEVEL_W-1:0] approach(input logic [LEVEL_W-1:0] from,
                                                  input logic [LEVEL_W-1:0] dest,
                                                  input logic [LEVEL_W-1:0] step);
    logic [LEVEL_W-1:0] res;
    res = from;
    if (from < dest) begin
      res = ((dest - from) > step) ? LEVEL_W'(from + step) : dest;
    end else if (from > dest) begin
      res = ((from - dest) > step) ? LEVEL_W'(from - step) : dest;
    end
    return res;
  endfunction

endpackage

FILE: design/led_brightness_fade_sequencer_core.sv
// top level of the led brightness fade sequencer
//
//   channel   dir   handshake          payload
//   in        in    in_valid/in_stall    lbfs_pkg::in_word_t
//   out       out   out_valid/out_stall  lbfs_pkg::out_word_t
//   cfg       in    cfg_we               cfg_addr, cfg_wdata
//
// a word that needs no ramp division is accepted, then written back
// a crossfade ramp word goes through the bit-serial divider before write back
// reset is synchronous, active low; all but sub_r, res_r, out_data_r reset
// a finished word waits in the output register while the next word is taken
`include "led_brightness_fade_sequencer_core_macros.svh"
module led_brightness_fade_sequencer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lbfs_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lbfs_pkg::out_word_t          out_data,
  input  logic                         cfg_we,
  input  logic [lbfs_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [lbfs_pkg::LEVEL_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_FADE_OUT, PH_FADE_IN, PH_XOUT, PH_XIN
  } phase_t;

  typedef enum logic [1:0] {
    ST_READY, ST_DIV, ST_WB
  } seq_st_t;

  localparam int LW = lbfs_pkg::LEVEL_W;
  localparam int MW = lbfs_pkg::MODE_W;

  seq_st_t             st_r, st_nxt;
  phase_t              phase_r, phase_nxt;
  logic [LW-1:0]       power_step_r, power_step_nxt;
  logic [LW-1:0]       out_steps_r, out_steps_nxt;
  logic [LW-1:0]       in_steps_r, in_steps_nxt;
  logic [MW-1:0]       remembered_r, remembered_nxt;
  logic [MW-1:0]       pending_r, pending_nxt;
  logic [LW-1:0]       ramp_r, ramp_nxt;
  logic [LW-1:0]       on_level_r, on_level_nxt;
  logic [LW-1:0]       cur_level_r, cur_level_nxt;
  logic                sub_r, sub_nxt;
  lbfs_pkg::out_word_t res_r, res_nxt;
  lbfs_pkg::out_word_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  lbfs_pkg::div_req_t  div_req;
  lbfs_pkg::div_rsp_t  div_rsp;

  logic                accept;
  logic [LW-1:0]       lv;
  logic [MW-1:0]       mv;
  logic [LW-1:0]       rc;
  logic [LW-1:0]       stepped;
  logic [LW-1:0]       fresh_on;
  logic [LW-1:0]       idle_on;
  logic [LW-1:0]       ramp_level;

  assign in_stall = (st_r != ST_READY);
  assign accept   = in_valid && !in_stall;
  assign lv       = in_data.level_in;
  assign mv       = in_data.effect_mode_in;
  assign rc       = ramp_r + 1'b1;
  assign fresh_on = (lv != '0) ? lv : lbfs_pkg::DEFAULT_ON;
  assign idle_on  = (lv != '0) ? lv : on_level_r;
  assign ramp_level = sub_r ? LW'(on_level_r - div_rsp.quot) : div_rsp.quot;

  always_comb begin
    st_nxt         = st_r;
    phase_nxt      = phase_r;
    power_step_nxt = power_step_r;
    out_steps_nxt  = out_steps_r;
    in_steps_nxt   = in_steps_r;
    remembered_nxt = remembered_r;
    pending_nxt    = pending_r;
    ramp_nxt       = ramp_r;
    on_level_nxt   = on_level_r;
    cur_level_nxt  = cur_level_r;
    sub_nxt        = sub_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    stepped        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = lbfs_pkg::PROD_W'(on_level_r) * lbfs_pkg::PROD_W'(rc);
    div_req.divisor  = out_steps_r;

    if (cfg_we) begin
      case (cfg_addr)
        lbfs_pkg::CFG_POWER_STEP: power_step_nxt = cfg_wdata;
        lbfs_pkg::CFG_OUT_STEPS:  out_steps_nxt  = cfg_wdata;
        lbfs_pkg::CFG_IN_STEPS:   in_steps_nxt   = cfg_wdata;
        default: ;
      endcase
    end

    case (st_r)
      ST_READY: begin
        if (accept) begin
          res_nxt.level_out       = lv;
          res_nxt.apply_mode      = 1'b0;
          res_nxt.effect_mode_out = '0;
          res_nxt.power_cmd       = lbfs_pkg::PCMD_NONE;
          st_nxt                  = ST_WB;
          case (in_data.mode)
            lbfs_pkg::KIND_FADE_IN: begin
              on_level_nxt      = fresh_on;
              remembered_nxt    = mv;
              cur_level_nxt     = '0;
              res_nxt.level_out = '0;
              res_nxt.power_cmd = lbfs_pkg::PCMD_ENABLE;
              ramp_nxt          = '0;
              phase_nxt         = PH_FADE_IN;
            end
            lbfs_pkg::KIND_FADE_OUT: begin
              on_level_nxt      = idle_on;
              cur_level_nxt     = idle_on;
              res_nxt.level_out = idle_on;
              ramp_nxt          = '0;
              phase_nxt         = PH_FADE_OUT;
            end
            lbfs_pkg::KIND_TICK: begin
              case (phase_r)
                PH_FADE_OUT: begin
                  stepped           = lbfs_pkg::approach(cur_level_r, '0, power_step_r);
                  cur_level_nxt     = stepped;
                  res_nxt.level_out = stepped;
                  if (stepped == '0) begin
                    res_nxt.power_cmd = lbfs_pkg::PCMD_DISABLE;
                    phase_nxt         = PH_IDLE;
                  end
                end
                PH_FADE_IN: begin
                  stepped = lbfs_pkg::approach(cur_level_r, on_level_r, power_step_r);
                  if (stepped >= on_level_r) begin
                    stepped   = on_level_r;
                    phase_nxt = PH_IDLE;
                  end
                  cur_level_nxt     = stepped;
                  res_nxt.level_out = stepped;
                end
                PH_XOUT: begin
                  if (rc >= out_steps_r) begin
                    cur_level_nxt     = '0;
                    res_nxt.level_out = '0;
                    if (pending_r != lbfs_pkg::NO_MODE) begin
                      res_nxt.apply_mode      = 1'b1;
                      res_nxt.effect_mode_out = pending_r;
                    end
                    pending_nxt = lbfs_pkg::NO_MODE;
                    ramp_nxt    = '0;
                    phase_nxt   = PH_XIN;
                  end else begin
                    ramp_nxt        = rc;
                    sub_nxt         = 1'b1;
                    div_req.start   = 1'b1;
                    div_req.divisor = out_steps_r;
                    st_nxt          = ST_DIV;
                  end
                end
                PH_XIN: begin
                  if (rc >= in_steps_r) begin
                    cur_level_nxt     = on_level_r;
                    res_nxt.level_out = on_level_r;
                    phase_nxt         = PH_IDLE;
                  end else begin
                    ramp_nxt        = rc;
                    sub_nxt         = 1'b0;
                    div_req.start   = 1'b1;
                    div_req.divisor = in_steps_r;
                    st_nxt          = ST_DIV;
                  end
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  if (remembered_r == lbfs_pkg::NO_MODE) begin
                    remembered_nxt = mv;
                    on_level_nxt   = fresh_on;
                  end else begin
                    on_level_nxt = idle_on;
                    if (mv != remembered_r) begin
                      res_nxt.apply_mode      = 1'b1;
                      res_nxt.effect_mode_out = remembered_r;
                      cur_level_nxt           = idle_on;
                      res_nxt.level_out       = idle_on;
                      pending_nxt             = mv;
                      remembered_nxt          = mv;
                      ramp_nxt                = '0;
                      phase_nxt               = PH_XOUT;
                    end
                  end
                end
              endcase
            end
            default: ;
          endcase
          res_nxt.busy_res = (phase_nxt != PH_IDLE);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          cur_level_nxt     = ramp_level;
          res_nxt.level_out = ramp_level;
          st_nxt            = ST_WB;
        end
      end
      ST_WB: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_READY;
        end
      end
      default: st_nxt = ST_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_READY;
      phase_r      <= PH_IDLE;
      power_step_r <= lbfs_pkg::RST_POWER_STEP;
      out_steps_r  <= lbfs_pkg::RST_OUT_STEPS;
      in_steps_r   <= lbfs_pkg::RST_IN_STEPS;
      remembered_r <= lbfs_pkg::NO_MODE;
      pending_r    <= lbfs_pkg::NO_MODE;
      ramp_r       <= '0;
      on_level_r   <= lbfs_pkg::DEFAULT_ON;
      cur_level_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      phase_r      <= phase_nxt;
      power_step_r <= power_step_nxt;
      out_steps_r  <= out_steps_nxt;
      in_steps_r   <= in_steps_nxt;
      remembered_r <= remembered_nxt;
      pending_r    <= pending_nxt;
      ramp_r       <= ramp_nxt;
      on_level_r   <= on_level_nxt;
      cur_level_r  <= cur_level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    sub_r      <= sub_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  lbfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LBFS_CHECK(a_done_in_div, div_rsp.done, st_r == ST_DIV)
  `LBFS_CHECK(a_disable_idle, out_valid_r && out_data_r.power_cmd == lbfs_pkg::PCMD_DISABLE, !out_data_r.busy_res)
  `LBFS_CHECK(a_enable_busy, out_valid_r && out_data_r.power_cmd == lbfs_pkg::PCMD_ENABLE, out_data_r.busy_res)
  `LBFS_CHECK(a_xin_no_pending, phase_r == PH_XIN, pending_r == lbfs_pkg::NO_MODE)

endmodule

FILE: design/lbfs_div.sv
// bit-serial restoring divider for the crossfade ramp level
`include "led_brightness_fade_sequencer_core_macros.svh"
module lbfs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lbfs_pkg::div_req_t req,
  output lbfs_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [lbfs_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [lbfs_pkg::LEVEL_W-1:0]  rem_r, rem_nxt;
  logic [lbfs_pkg::LEVEL_W-1:0]  dvs_r, dvs_nxt;
  logic [lbfs_pkg::PROD_W-1:0]   dq_r, dq_nxt;
  logic [lbfs_pkg::LEVEL_W:0]    shifted;
  logic [lbfs_pkg::LEVEL_W:0]    trial;
  logic                          ge;

  assign shifted = {rem_r, dq_r[lbfs_pkg::PROD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dq_nxt   = dq_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      dq_nxt   = req.dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[lbfs_pkg::LEVEL_W-1:0] : shifted[lbfs_pkg::LEVEL_W-1:0];
      dq_nxt  = {dq_r[lbfs_pkg::PROD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lbfs_pkg::CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dq_r  <= dq_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r[lbfs_pkg::LEVEL_W-1:0];

  `LBFS_CHECK(a_start_when_free, req.start, !busy_r)
  `LBFS_CHECK(a_done_not_busy, done_r, !busy_r)
  `LBFS_CHECK_NEXT(a_last_step_done, busy_r && !req.start && cnt_r == lbfs_pkg::CNT_LAST, done_r)

endmodule

FILE: test/tb_led_brightness_fade_sequencer_core.sv
// testbench of the led brightness fade sequencer: directed and random words checked against a predictor
module tb_led_brightness_fade_sequencer_core;
  import lbfs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 100;

  typedef enum logic [2:0] {
    ST_IDLE, PWR_OUT, PWR_IN, XF_OUT, XF_IN
  } fade_phase_t;

  class fade_scoreboard;
    logic [7:0]  power_step, out_steps, in_steps;
    fade_phase_t ph;
    logic [7:0]  seen_mode, next_mode, ramp_cnt, on_lvl, cur_lvl;
    out_word_t   expected_q[$];
    int          fail_cnt, checked, words, xfades, power_reqs;

    function new();
      power_step = RST_POWER_STEP;
      out_steps  = RST_OUT_STEPS;
      in_steps   = RST_IN_STEPS;
      ph         = ST_IDLE;
      seen_mode  = NO_MODE;
      next_mode  = NO_MODE;
      ramp_cnt   = '0;
      on_lvl     = DEFAULT_ON;
      cur_lvl    = '0;
    endfunction

    function void set_reg(logic [CFG_A_W-1:0] idx, logic [LEVEL_W-1:0] v);
      case (idx)
        CFG_POWER_STEP: power_step = v;
        CFG_OUT_STEPS:  out_steps = v;
        CFG_IN_STEPS:   in_steps = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] nudge_level(logic [7:0] a, logic [7:0] b, logic [7:0] by);
      int diff;
      diff = int'(b) - int'(a);
      if (diff > int'(by)) return a + by;
      if (diff < -int'(by)) return a - by;
      return b;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(in_word_t w);
      out_word_t e;
      e.level_out       = w.level_in;
      e.apply_mode      = 1'b0;
      e.effect_mode_out = '0;
      e.power_cmd       = PCMD_NONE;
      e.busy_res        = 1'b0;
      words++;
      case (w.mode)
        KIND_FADE_IN: begin
          on_lvl     = (w.level_in != 0) ? w.level_in : DEFAULT_ON;
          seen_mode  = w.effect_mode_in;
          cur_lvl    = '0;
          e.level_out = '0;
          e.power_cmd = PCMD_ENABLE;
          ramp_cnt   = '0;
          ph         = PWR_IN;
          power_reqs++;
        end
        KIND_FADE_OUT: begin
          if (w.level_in != 0) on_lvl = w.level_in;
          cur_lvl     = on_lvl;
          e.level_out = on_lvl;
          ramp_cnt    = '0;
          ph          = PWR_OUT;
          power_reqs++;
        end
        KIND_TICK: begin
          case (ph)
            PWR_OUT: begin
              cur_lvl = nudge_level(cur_lvl, 8'd0, power_step);
              e.level_out = cur_lvl;
              if (cur_lvl == 0) begin
                e.power_cmd = PCMD_DISABLE;
                ph = ST_IDLE;
              end
            end
            PWR_IN: begin
              cur_lvl = nudge_level(cur_lvl, on_lvl, power_step);
              if (cur_lvl >= on_lvl) begin
                cur_lvl = on_lvl;
                ph = ST_IDLE;
              end
              e.level_out = cur_lvl;
            end
            XF_OUT: begin
              ramp_cnt = ramp_cnt + 8'd1;
              if (ramp_cnt >= out_steps) begin
                cur_lvl = '0;
                if (next_mode != NO_MODE) begin
                  e.apply_mode = 1'b1;
                  e.effect_mode_out = next_mode;
                end
                next_mode = NO_MODE;
                ramp_cnt = '0;
                ph = XF_IN;
              end else begin
                cur_lvl = on_lvl - 8'(int'(on_lvl) * int'(ramp_cnt) / int'(out_steps));
              end
              e.level_out = cur_lvl;
            end
            XF_IN: begin
              ramp_cnt = ramp_cnt + 8'd1;
              if (ramp_cnt >= in_steps) begin
                cur_lvl = on_lvl;
                ph = ST_IDLE;
              end else begin
                cur_lvl = 8'(int'(on_lvl) * int'(ramp_cnt) / int'(in_steps));
              end
              e.level_out = cur_lvl;
            end
            default: begin
              ph = ST_IDLE;
              if (seen_mode == NO_MODE) begin
                seen_mode = w.effect_mode_in;
                on_lvl = (w.level_in != 0) ? w.level_in : DEFAULT_ON;
              end else begin
                if (w.level_in != 0) on_lvl = w.level_in;
                if (w.effect_mode_in != seen_mode) begin
                  e.apply_mode = 1'b1;
                  e.effect_mode_out = seen_mode;
                  cur_lvl = on_lvl;
                  e.level_out = on_lvl;
                  next_mode = w.effect_mode_in;
                  seen_mode = w.effect_mode_in;
                  ramp_cnt = '0;
                  ph = XF_OUT;
                  xfades++;
                end
              end
            end
          endcase
        end
        default: ;
      endcase
      e.busy_res = (ph != ST_IDLE);
      expected_q.push_back(e);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.level_out !== e.level_out) begin
        $error("level_out expected %0d got %0d", e.level_out, got.level_out);
        fail_cnt++;
      end
      if (got.apply_mode !== e.apply_mode) begin
        $error("apply_mode expected %0d got %0d", e.apply_mode, got.apply_mode);
        fail_cnt++;
      end
      if (got.effect_mode_out !== e.effect_mode_out) begin
        $error("effect_mode_out expected %0d got %0d", e.effect_mode_out, got.effect_mode_out);
        fail_cnt++;
      end
      if (got.power_cmd !== e.power_cmd) begin
        $error("power_cmd expected %0d got %0d", e.power_cmd, got.power_cmd);
        fail_cnt++;
      end
      if (got.busy_res !== e.busy_res) begin
        $error("busy_res expected %0d got %0d", e.busy_res, got.busy_res);
        fail_cnt++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_A_W-1:0]   cfg_addr = '0;
  logic [LEVEL_W-1:0]   cfg_wdata = '0;

  fade_scoreboard sb = new();
  int  cycle_cnt = 0;
  int  settings = 0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;
  logic [MODE_W-1:0] host_mode = 8'd0;

  led_brightness_fade_sequencer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls, with long hold-offs while the sender keeps going
  initial begin
    int  stall_left;
    int  next_hold;
    stall_left = 0;
    next_hold = 150;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (sb.checked >= next_hold) begin
        stall_left = 400;
        next_hold = next_hold + 450;
      end else if (!rx_quiet) begin
        stall_left = gap_len();
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_word(logic [KIND_W-1:0] kind, logic [MODE_W-1:0] eff,
                           logic [LEVEL_W-1:0] lvl);
    int gap;
    gap = tx_quiet ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: kind, effect_mode_in: eff, level_in: lvl};
    do @(posedge clk); while (in_stall);
  endtask

  // step past the current edge first so the last accepted word is already in the scoreboard
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [LEVEL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [7:0] ps, logic [7:0] os, logic [7:0] is);
    write_reg(CFG_POWER_STEP, ps);
    write_reg(CFG_OUT_STEPS, os);
    write_reg(CFG_IN_STEPS, is);
    settings++;
  endtask

  task automatic random_word();
    int r;
    logic [KIND_W-1:0]  kind;
    logic [LEVEL_W-1:0] lvl;
    r = $urandom_range(0, 99);
    if (r < 3) kind = KIND_UNUSED;
    else if (r < 9) kind = KIND_FADE_IN;
    else if (r < 15) kind = KIND_FADE_OUT;
    else kind = KIND_TICK;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      r = $urandom_range(0, 99);
      if (r < 5) host_mode = NO_MODE;
      else if (r < 50) host_mode = 8'($urandom_range(0, 3));
      else host_mode = 8'($urandom_range(0, 254));
    end
    r = $urandom_range(0, 99);
    if (r < 10) lvl = 8'd0;
    else if (r < 15) lvl = 8'hFF;
    else lvl = 8'($urandom_range(0, 255));
    send_word(kind, host_mode, lvl);
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings
    send_word(KIND_UNUSED, NO_MODE, 8'hFF);
    send_word(KIND_TICK, 8'd5, 8'd0);
    send_word(KIND_TICK, 8'd5, 8'd200);
    send_word(KIND_TICK, 8'd7, 8'd0);
    repeat (3) send_word(KIND_TICK, 8'd7, 8'd33);
    // ramp length lowered in the middle of a crossfade
    settle();
    write_reg(CFG_OUT_STEPS, 8'd2);
    send_word(KIND_TICK, 8'd7, 8'd33);
    settle();
    write_reg(CFG_IN_STEPS, 8'd0);
    send_word(KIND_TICK, 8'd7, 8'd33);
    send_word(KIND_FADE_OUT, 8'd7, 8'd0);
    settle();
    write_reg(CFG_POWER_STEP, 8'd255);
    send_word(KIND_TICK, 8'd7, 8'd90);
    send_word(KIND_FADE_IN, NO_MODE, 8'd0);
    send_word(KIND_TICK, NO_MODE, 8'd50);
    send_word(KIND_TICK, 8'd9, 8'd255);
    send_word(KIND_TICK, 8'd254, 8'd1);
    settle();
    write_reg(CFG_OUT_STEPS, 8'd0);
    send_word(KIND_TICK, 8'd254, 8'd1);
    // power step of zero never finishes a fade
    settle();
    write_reg(CFG_POWER_STEP, 8'd0);
    send_word(KIND_FADE_OUT, 8'd254, 8'd77);
    send_word(KIND_TICK, 8'd254, 8'd77);
    send_word(KIND_FADE_IN, 8'd3, 8'd255);
    send_word(KIND_TICK, 8'd3, 8'd255);
    send_word(KIND_FADE_OUT, 8'd3, 8'd0);
    settle();
    write_reg(CFG_POWER_STEP, 8'd255);
    send_word(KIND_TICK, 8'd3, 8'd0);
    send_word(KIND_TICK, NO_MODE, 8'd10);
    send_word(KIND_TICK, NO_MODE, 8'd10);
    send_word(KIND_TICK, NO_MODE, 8'd10);
    send_word(KIND_TICK, 8'd4, 8'd0);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: write_all(8'd1, 8'd1, 8'd1);
        1: write_all(8'd255, 8'd255, 8'd255);
        2: write_all(RST_POWER_STEP, RST_OUT_STEPS, RST_IN_STEPS);
        default: write_all(($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 16)),
                           8'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8)),
                           8'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8)));
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) random_word();
      settle();
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (40) @(posedge clk);
    $display("covered %0d words, %0d results, %0d register settings", sb.words, sb.checked,
             settings);
    $display("with %0d crossfades and %0d power fade requests", sb.xfades, sb.power_reqs);
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
